FILE: rtl/ansi_text_console_parser_defines.svh
// ----------------------------------------------------------------------------
// ANSI text console parser assertion macros
// Shared property forms; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_CONSOLE_PARSER_DEFINES_SVH
`define ANSI_TEXT_CONSOLE_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATCP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ATCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/atcp_pkg.sv
// ----------------------------------------------------------------------------
// ANSI text console parser package
// Types, character codes, SGR codes and the 16-color palette.
// ----------------------------------------------------------------------------
`default_nettype none

package atcp_pkg;

	localparam int PARAM_SLOTS_DEF = 8;
	localparam int CFG_INDEX_W     = 1;
	localparam int CFG_DATA_W      = 8;

	localparam logic [7:0]  COLS_RESET = 8'd80;
	localparam logic [6:0]  ROWS_RESET = 7'd25;
	localparam logic [23:0] WHITE_RGB  = 24'hFFFFFF;
	localparam logic [23:0] BLACK_RGB  = 24'h000000;

	// Character codes.
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SGR_M  = 8'h6D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// SGR parameter values.
	localparam logic [7:0] SGR_RESET  = 8'd0;
	localparam logic [7:0] SGR_FG_LO  = 8'd30;
	localparam logic [7:0] SGR_FG_HI  = 8'd37;
	localparam logic [7:0] SGR_BG_LO  = 8'd40;
	localparam logic [7:0] SGR_BG_HI  = 8'd47;
	localparam logic [7:0] SGR_FGB_LO = 8'd90;
	localparam logic [7:0] SGR_FGB_HI = 8'd97;
	localparam logic [7:0] PARAM_SAT  = 8'd255;
	localparam logic [3:0] DEC_BASE   = 4'd10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TEXT_COLUMNS = 1'b0,
		CFG_TEXT_ROWS    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} parse_mode_t;

	typedef enum logic [0:0] {
		EV_GLYPH  = 1'b0,
		EV_SCROLL = 1'b1
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_APPLY  = 2'd1,
		ST_SCROLL = 2'd2
	} ctrl_state_t;

	typedef struct packed {
		logic take_char;
		logic apply_step;
		logic push_scroll;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fifo_room;
		logic start_apply;
		logic scroll_after;
		logic sweep_last;
	} dp_status_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  col;
		logic [6:0]  row;
		logic [7:0]  glyph;
		logic [23:0] fore;
		logic [23:0] back;
		logic        last;
	} result_t;

	function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
		logic [23:0] rgb;
		case (idx)
			4'd0:    rgb = 24'h000000;
			4'd1:    rgb = 24'hAA0000;
			4'd2:    rgb = 24'h00AA00;
			4'd3:    rgb = 24'hAA5500;
			4'd4:    rgb = 24'h0000AA;
			4'd5:    rgb = 24'hAA00AA;
			4'd6:    rgb = 24'h00AAAA;
			4'd7:    rgb = 24'hAAAAAA;
			4'd8:    rgb = 24'h555555;
			4'd9:    rgb = 24'hFF5555;
			4'd10:   rgb = 24'h55FF55;
			4'd11:   rgb = 24'hFFFF55;
			4'd12:   rgb = 24'h5555FF;
			4'd13:   rgb = 24'hFF55FF;
			4'd14:   rgb = 24'h55FFFF;
			default: rgb = 24'hFFFFFF;
		endcase
		return rgb;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/atcp_ctrl.sv
// ----------------------------------------------------------------------------
// ANSI text console parser controller
// Input handshake and sequencing of SGR application and trailing scrolls.
// ----------------------------------------------------------------------------
`default_nettype none

module atcp_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  char_valid,
	output logic                       char_stall,
	input  wire atcp_pkg::dp_status_t  st,
	output atcp_pkg::ctrl_cmd_t        cmd
);
	import atcp_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		char_stall      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				char_stall    = !st.fifo_room;
				cmd.take_char = char_valid && st.fifo_room;
				if (cmd.take_char) begin
					if (st.start_apply) begin
						state_d = ST_APPLY;
					end else if (st.scroll_after) begin
						state_d = ST_SCROLL;
					end
				end
			end
			ST_APPLY: begin
				cmd.apply_step = 1'b1;
				if (st.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				cmd.push_scroll = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/atcp_datapath.sv
// ----------------------------------------------------------------------------
// ANSI text console parser datapath
// Escape parser state, parameter store, cursor, colors and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module atcp_datapath #(
	parameter int PARAM_SLOTS = atcp_pkg::PARAM_SLOTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic [7:0]                           char_code,
	input  wire logic                                 cfg_valid,
	input  wire logic [atcp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [atcp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire atcp_pkg::ctrl_cmd_t                  cmd,
	output atcp_pkg::dp_status_t                      st,
	output logic                                      event_valid,
	input  wire logic                                 event_stall,
	output atcp_pkg::result_t                         head
);
	import atcp_pkg::*;

	localparam int PIDX_W    = $clog2(PARAM_SLOTS);
	localparam int FIFO_DEPTH = 3;

	// Configuration and parser state.
	logic [7:0]        cols_q;
	logic [6:0]        rows_q;
	parse_mode_t       mode_q;
	logic [PIDX_W-1:0] count_q;
	logic [PIDX_W-1:0] sweep_q;
	logic [7:0]        ccol_q;
	logic [6:0]        crow_q;
	logic [23:0]       fore_q;
	logic [23:0]       back_q;
	logic [7:0]        params_q [PARAM_SLOTS];

	// Result queue.
	result_t           fifo_q [FIFO_DEPTH];
	logic [1:0]        wr_q;
	logic [1:0]        rd_q;
	logic [1:0]        fill_q;

	// Decode.
	logic              in_esc, in_csi, esc_bracket, text_path;
	logic              is_digit, is_semi, is_ordinary, is_lf, is_cr;
	logic              glyph_ok, do_glyph, wrap, line_adv, scroll;
	logic [8:0]        col_inc;
	logic [7:0]        row_inc;
	logic [6:0]        rows_m1;
	logic              semi_room;

	// Parameter store access.
	logic [PIDX_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic [11:0]       acc;
	logic [7:0]        acc_sat;
	logic              p_we;
	logic [PIDX_W-1:0] p_waddr;
	logic [7:0]        p_wdata;

	logic              push, pop;
	result_t           push_data;

	always_comb begin
		in_esc      = (mode_q == MODE_ESC);
		in_csi      = (mode_q == MODE_CSI);
		esc_bracket = in_esc && (char_code == CH_LBRACK);
		text_path   = !in_csi && !esc_bracket;
		is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_semi     = (char_code == CH_SEMI);
		is_lf       = text_path && (char_code == CH_LF);
		is_cr       = text_path && (char_code == CH_CR);
		is_ordinary = text_path && (char_code != CH_ESC) && (char_code != CH_LF)
			&& (char_code != CH_CR);
		glyph_ok    = (ccol_q < cols_q) && (crow_q < rows_q);
		do_glyph    = is_ordinary && glyph_ok;
		col_inc     = {1'b0, ccol_q} + 9'd1;
		wrap        = (col_inc >= {1'b0, cols_q});
		line_adv    = is_lf || (is_ordinary && wrap);
		row_inc     = {1'b0, crow_q} + 8'd1;
		scroll      = line_adv && (row_inc >= {1'b0, rows_q});
		rows_m1     = rows_q - 7'd1;
		semi_room   = (count_q < PIDX_W'(PARAM_SLOTS - 1));
	end

	// One read port shared by digit accumulation and the SGR sweep.
	assign rd_addr = cmd.apply_step ? sweep_q : count_q;
	assign rd_data = params_q[rd_addr];

	always_comb begin
		acc     = ({4'b0, rd_data} * {8'b0, DEC_BASE}) + {8'b0, char_code[3:0]};
		acc_sat = (acc > {4'b0, PARAM_SAT}) ? PARAM_SAT : acc[7:0];
		p_we    = 1'b0;
		p_waddr = count_q;
		p_wdata = acc_sat;
		if (cmd.take_char) begin
			if (esc_bracket) begin
				p_we    = 1'b1;
				p_waddr = '0;
				p_wdata = '0;
			end else if (in_csi && is_digit) begin
				p_we    = 1'b1;
			end else if (in_csi && is_semi && semi_room) begin
				p_we    = 1'b1;
				p_waddr = count_q + PIDX_W'(1);
				p_wdata = '0;
			end
		end
	end

	assign st.fifo_room    = (fill_q <= 2'd1);
	assign st.start_apply  = in_csi && (char_code == CH_SGR_M);
	assign st.scroll_after = do_glyph && scroll;
	assign st.sweep_last   = (sweep_q == count_q);

	always_ff @(posedge clk) begin
		if (p_we) begin
			params_q[p_waddr] <= p_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q  <= COLS_RESET;
			rows_q  <= ROWS_RESET;
			mode_q  <= MODE_NORMAL;
			count_q <= '0;
			sweep_q <= '0;
			ccol_q  <= '0;
			crow_q  <= '0;
			fore_q  <= WHITE_RGB;
			back_q  <= BLACK_RGB;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					CFG_TEXT_COLUMNS: cols_q <= cfg_data;
					CFG_TEXT_ROWS:    rows_q <= cfg_data[6:0];
					default: begin
					end
				endcase
			end
			if (cmd.take_char) begin
				sweep_q <= '0;
				if (esc_bracket) begin
					mode_q  <= MODE_CSI;
					count_q <= '0;
				end else if (in_csi) begin
					if (is_semi) begin
						if (semi_room) begin
							count_q <= count_q + PIDX_W'(1);
						end
					end else if (!is_digit) begin
						mode_q <= MODE_NORMAL;
					end
				end else if (char_code == CH_ESC) begin
					mode_q <= MODE_ESC;
				end else begin
					mode_q <= MODE_NORMAL;
				end
				if (line_adv) begin
					ccol_q <= '0;
					crow_q <= scroll ? rows_m1 : row_inc[6:0];
				end else if (is_cr) begin
					ccol_q <= '0;
				end else if (is_ordinary) begin
					ccol_q <= col_inc[7:0];
				end
			end
			if (cmd.apply_step) begin
				sweep_q <= sweep_q + PIDX_W'(1);
				if (rd_data == SGR_RESET) begin
					fore_q <= WHITE_RGB;
					back_q <= BLACK_RGB;
				end else if ((rd_data >= SGR_FG_LO) && (rd_data <= SGR_FG_HI)) begin
					fore_q <= palette_rgb({1'b0, 3'(rd_data - SGR_FG_LO)});
				end else if ((rd_data >= SGR_FGB_LO) && (rd_data <= SGR_FGB_HI)) begin
					fore_q <= palette_rgb({1'b1, 3'(rd_data - SGR_FGB_LO)});
				end else if ((rd_data >= SGR_BG_LO) && (rd_data <= SGR_BG_HI)) begin
					back_q <= palette_rgb({1'b0, 3'(rd_data - SGR_BG_LO)});
				end
			end
		end
	end

	// A glyph goes in with the item; a scroll that follows it goes in on the next cycle.
	always_comb begin
		push            = (cmd.take_char && (do_glyph || scroll)) || cmd.push_scroll;
		push_data.kind  = EV_SCROLL;
		push_data.col   = '0;
		push_data.row   = '0;
		push_data.glyph = '0;
		push_data.fore  = fore_q;
		push_data.back  = back_q;
		push_data.last  = 1'b1;
		if (cmd.take_char && do_glyph) begin
			push_data.kind  = EV_GLYPH;
			push_data.col   = ccol_q;
			push_data.row   = crow_q;
			push_data.glyph = char_code;
			push_data.last  = !scroll;
		end
	end

	assign event_valid = (fill_q != 2'd0);
	assign pop         = event_valid && !event_stall;
	assign head        = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= (rd_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ansi_text_console_parser.sv
// ----------------------------------------------------------------------------
// ANSI text console parser
// Byte-stream console parser producing glyph draw and scroll events.
// ----------------------------------------------------------------------------
// One byte is taken per item. Escape and parameter bytes produce no event.
// An ordinary byte yields a draw event when the cursor lies on screen. When
// that draw is followed by a scroll, the scroll is queued in the following
// cycle and the next byte waits for it. A scroll with no draw before it is
// queued in the byte's own cycle: a line feed, or a wrap from a cursor left
// off screen. An SGR terminator 'm' stalls the next byte while the colors are
// updated by a single sweep over the stored parameters (up to PARAM_SLOTS).
// Events leave through a three-entry queue; when no sweep or scroll is pending,
// the next byte is accepted whenever at most one event is still waiting.
// Configuration writes are always ready and take effect at once.
`default_nettype none

module ansi_text_console_parser #(
	parameter int PARAM_SLOTS = atcp_pkg::PARAM_SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              char_valid,
	output logic                                   char_stall,
	input  wire logic [7:0]                        char_code,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [atcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [atcp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                                   event_valid,
	input  wire logic                              event_stall,
	output logic                                   event_kind,
	output logic [7:0]                             cell_column,
	output logic [6:0]                             cell_row,
	output logic [7:0]                             glyph_code,
	output logic [23:0]                            fore_rgb,
	output logic [23:0]                            back_rgb,
	output logic                                   last_event
);
	import atcp_pkg::*;

	`include "ansi_text_console_parser_defines.svh"

	ctrl_cmd_t  cmd;
	dp_status_t st;
	result_t    head;

	assign cfg_ready = 1'b1;

	atcp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.st         (st),
		.cmd        (cmd)
	);

	atcp_datapath #(
		.PARAM_SLOTS (PARAM_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.head        (head)
	);

	assign event_kind  = head.kind;
	assign cell_column = head.col;
	assign cell_row    = head.row;
	assign glyph_code  = head.glyph;
	assign fore_rgb    = head.fore;
	assign back_rgb    = head.back;
	assign last_event  = head.last;

	`ATCP_ASSERT_IMPLY(a_no_take_apply, cmd.apply_step, char_stall && !cmd.take_char, "take in sweep")
	`ATCP_ASSERT_NEXT(a_scroll_follows, cmd.take_char && st.scroll_after, cmd.push_scroll, "no scroll")
	`ATCP_ASSERT_IMPLY(a_scroll_after_take, cmd.push_scroll, $past(cmd.take_char), "stray scroll")

endmodule

`default_nettype wire
